>>> rtl/ihex_pkg.sv
// ============================================================================
// Intel HEX record parser package
// Types, constants and the hex digit decoder shared by the parser modules.
// ============================================================================
package ihex_pkg;

   // Character position within a record and byte index within the record.
   localparam int POS_W = 10;
   localparam int IDX_W = POS_W - 1;
   localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REGION0 = 3'd1;

   // Operating modes.
   localparam logic [1:0] MODE_FULL     = 2'd0;
   localparam logic [1:0] MODE_CSUM     = 2'd1;
   localparam logic [1:0] MODE_ADDR     = 2'd2;
   localparam logic [1:0] MODE_CSUM_ALT = 2'd3;

   // Record status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DATA_OK  = 3'd1;
   localparam logic [2:0] ST_EOF      = 3'd2;
   localparam logic [2:0] ST_INCOMPAT = 3'd3;
   localparam logic [2:0] ST_CSUM_ERR = 3'd4;
   localparam logic [2:0] ST_BAD_ADDR = 3'd5;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Record types.
   localparam logic [7:0] REC_DATA       = 8'h00;
   localparam logic [7:0] REC_EOF        = 8'h01;
   localparam logic [7:0] REC_EXT_LINEAR = 8'h04;

   // Byte indexes of the header fields and the first data byte.
   localparam logic [IDX_W-1:0] IDX_COUNT   = 9'd0;
   localparam logic [IDX_W-1:0] IDX_ADDR_HI = 9'd1;
   localparam logic [IDX_W-1:0] IDX_ADDR_LO = 9'd2;
   localparam logic [IDX_W-1:0] IDX_TYPE    = 9'd3;
   localparam logic [IDX_W-1:0] IDX_DATA    = 9'd4;
   localparam logic [IDX_W-1:0] IDX_OFS_LO  = 9'd5;

   // Error flag bits.
   localparam int ERR_COLON     = 0;
   localparam int ERR_MALFORMED = 1;

   // ASCII codes.
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] ASCII_DIGIT_OFS = 8'd48;
   localparam logic [7:0] ASCII_UPPER_OFS = 8'd55;
   localparam logic [7:0] ASCII_LOWER_OFS = 8'd87;

   // Result word width, padded to whole bytes.
   localparam int RSP_TDATA_W = 56;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [31:0] byte_address;
      logic [2:0]  status;
      logic [7:0]  chunk_size;
   } result_type;

   // Decode one ASCII hex digit; a non-hex character gives zero and not ok.
   function automatic nibble_type hex_decode(input logic [7:0] c);
      nibble_type r;
      logic [7:0] d;
      r.ok = 1'b1;
      d    = 8'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         d = c - ASCII_DIGIT_OFS;
      end else if (c >= 8'd65 && c <= 8'd70) begin
         d = c - ASCII_UPPER_OFS;
      end else if (c >= 8'd97 && c <= 8'd102) begin
         d = c - ASCII_LOWER_OFS;
      end else begin
         r.ok = 1'b0;
      end
      r.value = d[3:0];
      return r;
   endfunction

endpackage

>>> rtl/intel_hex_record_parser.sv
// Each character is held in the input register; its status or data word is then registered
// in the output register, from which rsp_ can take it.
// Throughput: one character per cycle while the result stream is not stalled.
// The input register refills in the same cycle it hands its word on, so no bubbles form.
// Reset is synchronous and active high: it clears record state, upper offset,
// mode and region bounds, and empties both the input and output registers.
// ============================================================================
// Intel HEX record parser
// Parses ASCII Intel HEX records one character per word and reports data
// bytes and a per-record status with checksum and address region checks.
// ============================================================================
module intel_hex_record_parser #(
   parameter int NUM_REGIONS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // Character stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ch[7:0]
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // data_byte[7:0], byte_address[39:8], status[42:40], chunk_size[50:43]
   output logic [ihex_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // kind[0]
   output logic                                rsp_tuser,
   // Configuration writes.
   input  logic                                csr_wr_en,
   input  logic [ihex_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ihex_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [1:0]                   mode_ff;
   logic [NUM_REGIONS-1:0][63:0] region_ff;

   logic                         in_valid_ff;
   logic [7:0]                   ch_ff;
   logic                         end_ff;

   logic                         out_free;
   logic                         step;
   logic                         res_valid;
   ihex_pkg::result_type         res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ihex_pkg::MODE_FULL;
      end else if (csr_wr_en && csr_index == ihex_pkg::REG_MODE) begin
         mode_ff <= csr_wdata[1:0];
      end
   end

   for (genvar k = 0; k < NUM_REGIONS; k++) begin : g_region
      always_ff @(posedge clock) begin
         if (reset) begin
            region_ff[k] <= '0;
         end else if (csr_wr_en &&
                      csr_index == ihex_pkg::CSR_INDEX_W'(ihex_pkg::REG_REGION0 + k)) begin
            region_ff[k] <= csr_wdata;
         end
      end
   end

   // Input register: a word moves on whenever the output side has room.
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         ch_ff  <= req_tdata;
         end_ff <= req_tlast;
      end
   end

   ihex_record #(
      .NUM_REGIONS (NUM_REGIONS)
   ) u_record (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .ch            (ch_ff),
      .record_end    (end_ff),
      .mode          (mode_ff),
      .region_bounds (region_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   ihex_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/ihex_region_check.sv
// ============================================================================
// Address region check
// Tells whether an address lies in any of the configured [base, limit) ranges.
// ============================================================================
module ihex_region_check #(
   parameter int NUM_REGIONS = 4
) (
   input  logic [NUM_REGIONS-1:0][63:0] region_bounds,
   input  logic [31:0]                  address,
   output logic                         hit
);

   logic [NUM_REGIONS-1:0] in_region;

   // Each region compares independently; the hits are ORed.
   always_comb begin
      for (int k = 0; k < NUM_REGIONS; k++) begin
         in_region[k] = (address >= region_bounds[k][31:0]) &&
                        (address <  region_bounds[k][63:32]);
      end
   end

   assign hit = |in_region;

endmodule

>>> rtl/ihex_out_stage.sv
// ============================================================================
// Result output register
// Holds one result word until the downstream side takes it.
// ============================================================================
module ihex_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic                              res_valid,
   input  ihex_pkg::result_type              res,
   output logic                              out_free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // data_byte[7:0], byte_address[39:8], status[42:40], chunk_size[50:43]
   output logic [ihex_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // kind[0]
   output logic                              rsp_tuser
);

   logic                 valid_ff;
   ihex_pkg::result_type data_ff;

   // The register can take a new word when empty or when its word leaves now.
   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= load && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tdata  = {5'd0, data_ff.chunk_size, data_ff.status,
                        data_ff.byte_address, data_ff.data_byte};

endmodule

>>> rtl/ihex_record.sv
// ============================================================================
// Record state and character decoder
// Consumes one character per step, keeps the record state and forms results.
// ============================================================================
module ihex_record #(
   parameter int NUM_REGIONS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    ch,
   input  logic                          record_end,
   input  logic [1:0]                    mode,
   input  logic [NUM_REGIONS-1:0][63:0]  region_bounds,
   output logic                          res_valid,
   output ihex_pkg::result_type          res
);

   logic [ihex_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [3:0]                 hi_ff, hi_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [7:0]                 count_ff, count_in;
   logic [15:0]                addr_ff, addr_in;
   logic [7:0]                 type_ff, type_in;
   logic [15:0]                pending_ff, pending_in;
   logic [15:0]                upper_ff, upper_in;
   logic [1:0]                 err_ff, err_in;

   ihex_pkg::nibble_type       nib;
   logic                       at_max;
   logic                       first_char;
   logic                       digit;
   logic                       byte_done;
   logic [7:0]                 byte_val;
   logic [ihex_pkg::IDX_W-1:0] idx;
   logic [ihex_pkg::IDX_W-1:0] data_idx;
   logic                       emit;
   logic [31:0]                start_end;
   logic                       region_hit;
   logic                       digits_bad;
   logic [2:0]                 status;
   logic [7:0]                 chunk;
   logic                       load_upper;

   // Character classification.
   assign nib        = ihex_pkg::hex_decode(ch);
   assign at_max     = (pos_ff == ihex_pkg::POS_MAX);
   assign first_char = (pos_ff == '0);
   assign digit      = !at_max && !first_char;
   assign byte_done  = digit && !pos_ff[0];
   assign byte_val   = {hi_ff, nib.value};
   assign idx        = pos_ff[ihex_pkg::POS_W-1:1] - 9'd1;
   assign data_idx   = idx - ihex_pkg::IDX_DATA;

   // Next record state from this character.
   always_comb begin
      pos_in     = pos_ff;
      hi_in      = hi_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      type_in    = type_ff;
      pending_in = pending_ff;
      err_in     = err_ff;
      if (at_max) begin
         err_in[ihex_pkg::ERR_MALFORMED] = 1'b1;
      end else begin
         pos_in = pos_ff + 10'd1;
         if (first_char) begin
            if (ch != ihex_pkg::CHAR_COLON) begin
               err_in[ihex_pkg::ERR_COLON] = 1'b1;
            end
         end else if (!nib.ok) begin
            err_in[ihex_pkg::ERR_MALFORMED] = 1'b1;
         end
      end
      if (digit && pos_ff[0]) begin
         hi_in = nib.value;
      end
      if (byte_done) begin
         sum_in = sum_ff + byte_val;
         unique case (idx)
            ihex_pkg::IDX_COUNT:   count_in = byte_val;
            ihex_pkg::IDX_ADDR_HI: addr_in[15:8] = byte_val;
            ihex_pkg::IDX_ADDR_LO: addr_in[7:0] = byte_val;
            ihex_pkg::IDX_TYPE:    type_in = byte_val;
            ihex_pkg::IDX_DATA:    pending_in[15:8] = byte_val;
            ihex_pkg::IDX_OFS_LO:  pending_in[7:0] = byte_val;
            default: ;
         endcase
      end
   end

   // Tentative data byte emission.
   assign emit = byte_done && (idx >= ihex_pkg::IDX_DATA) &&
                 (mode == ihex_pkg::MODE_FULL) && (type_ff == ihex_pkg::REC_DATA) &&
                 (err_in == 2'b00) && (data_idx < {1'b0, count_ff});

   // Record start address as seen at the end of the record.
   assign start_end = {upper_ff, addr_in};

   ihex_region_check #(
      .NUM_REGIONS (NUM_REGIONS)
   ) u_region_check (
      .region_bounds (region_bounds),
      .address       (start_end),
      .hit           (region_hit)
   );

   // The digit count is the new position less one: it must be even and at least two.
   assign digits_bad = (pos_in < 10'd3) || !pos_in[0];

   // Status decision in priority order.
   always_comb begin
      status     = ihex_pkg::ST_OK;
      chunk      = 8'd0;
      load_upper = 1'b0;
      if (err_in[ihex_pkg::ERR_COLON]) begin
         status = ihex_pkg::ST_INCOMPAT;
      end else if (err_in[ihex_pkg::ERR_MALFORMED] || digits_bad || (sum_in != 8'd0)) begin
         status = ihex_pkg::ST_CSUM_ERR;
      end else if (mode == ihex_pkg::MODE_CSUM || mode == ihex_pkg::MODE_CSUM_ALT) begin
         status = ihex_pkg::ST_OK;
      end else begin
         case (type_in)
            ihex_pkg::REC_DATA: begin
               if (!region_hit) begin
                  status = ihex_pkg::ST_BAD_ADDR;
               end else if (mode == ihex_pkg::MODE_FULL) begin
                  status = ihex_pkg::ST_DATA_OK;
                  chunk  = count_in;
               end else begin
                  status = ihex_pkg::ST_OK;
               end
            end
            ihex_pkg::REC_EOF: begin
               status = ihex_pkg::ST_EOF;
            end
            ihex_pkg::REC_EXT_LINEAR: begin
               status     = ihex_pkg::ST_OK;
               load_upper = 1'b1;
            end
            default: begin
               status = ihex_pkg::ST_INCOMPAT;
            end
         endcase
      end
   end

   // Result word: the status on the last character, otherwise a data byte.
   always_comb begin
      if (record_end) begin
         res_valid        = 1'b1;
         res.kind         = ihex_pkg::KIND_STATUS;
         res.data_byte    = 8'd0;
         res.byte_address = start_end;
         res.status       = status;
         res.chunk_size   = chunk;
      end else begin
         res_valid        = emit;
         res.kind         = ihex_pkg::KIND_DATA;
         res.data_byte    = byte_val;
         res.byte_address = {upper_ff, addr_ff} + {23'd0, data_idx};
         res.status       = ihex_pkg::ST_OK;
         res.chunk_size   = 8'd0;
      end
   end

   // The upper offset changes only on a valid extended linear address record.
   assign upper_in = (record_end && load_upper) ? pending_in : upper_ff;

   // Record state; everything but the upper offset clears at the end of a record.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         hi_ff      <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         addr_ff    <= '0;
         type_ff    <= '0;
         pending_ff <= '0;
         upper_ff   <= '0;
         err_ff     <= '0;
      end else if (step) begin
         upper_ff <= upper_in;
         if (record_end) begin
            pos_ff     <= '0;
            hi_ff      <= '0;
            sum_ff     <= '0;
            count_ff   <= '0;
            addr_ff    <= '0;
            type_ff    <= '0;
            pending_ff <= '0;
            err_ff     <= '0;
         end else begin
            pos_ff     <= pos_in;
            hi_ff      <= hi_in;
            sum_ff     <= sum_in;
            count_ff   <= count_in;
            addr_ff    <= addr_in;
            type_ff    <= type_in;
            pending_ff <= pending_in;
            err_ff     <= err_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // Data bytes come only in full mode and only from error-free records.
   a_data_only_full: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && (res.kind == ihex_pkg::KIND_DATA) |->
         (mode == ihex_pkg::MODE_FULL) && (err_ff == 2'b00))
      else $error("data byte emitted outside full mode or after an error");

   // A record end always returns the position to the start.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && record_end |=> (pos_ff == '0) && (err_ff == 2'b00))
      else $error("record state not cleared after record end");

   // The upper offset moves only at the end of a record.
   a_upper_stable: assert property (@(posedge clock) disable iff (reset)
      !(step && record_end) |=> $stable(upper_ff))
      else $error("upper offset changed in the middle of a record");

   // A chunk size is reported only with the data ok status.
   a_chunk_with_data_ok: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && (res.chunk_size != 8'd0) |->
         (res.kind == ihex_pkg::KIND_STATUS) && (res.status == ihex_pkg::ST_DATA_OK))
      else $error("chunk size given without data ok status");
`endif

endmodule
